// File: design/wbrl_pkg.sv
// ----------------------------------------------------------------------------
// wbrl_pkg
// Shared types and constants of the write buffer rate limiter: command and
// register codes, the per-buffer state entry and the rate unit interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package wbrl_pkg;

    // Buffer organization
    localparam int NUM_BUFFERS  = 4;
    localparam int ADDR_W       = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int WINDOW_ORDER = 6;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 2;
    localparam int CNT_W   = 16;
    localparam int FREE_W  = 24;
    localparam int SHIFT_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [FREE_W-1:0] FREE_MAX = '1;

    // Register reset values
    localparam logic [FREE_W-1:0]  RST_HIGH_MARK    = 24'd4096;
    localparam logic [SHIFT_W-1:0] RST_WINDOW_SHIFT = 5'd8;
    localparam logic [FREE_W-1:0]  RST_RESERVE      = 24'd64;
    localparam logic [CNT_W-1:0]   RST_BUDGET       = 16'd256;
    localparam logic [CNT_W-1:0]   RST_IDLE_TIMEOUT = 16'd5000;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY    = 3'd0,
        CMD_USER_IN  = 3'd1,
        CMD_GC_IN    = 3'd2,
        CMD_OUT      = 3'd3,
        CMD_FREE_INC = 3'd4,
        CMD_FREE_DEC = 3'd5,
        CMD_KICK     = 3'd6,
        CMD_TICK     = 3'd7
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_MARK    = 3'd0,
        CFG_WINDOW_SHIFT = 3'd1,
        CFG_RESERVE      = 3'd2,
        CFG_BUDGET       = 3'd3,
        CFG_IDLE_TIMEOUT = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2
    } t_gc_action;

    // One buffer's state as stored in the buffer memory
    typedef struct packed {
        logic [CNT_W-1:0] user_cnt;
        logic [CNT_W-1:0] gc_cnt;
        logic             active;
        logic [CNT_W-1:0] countdown;
    } t_buf_entry;

    // Configuration seen by the rate unit
    typedef struct packed {
        logic [FREE_W-1:0]  high_mark;
        logic [SHIFT_W-1:0] window_shift;
        logic [FREE_W-1:0]  reserve;
        logic [CNT_W-1:0]   budget;
    } t_rate_cfg;

    // Requests from the sequencer to the rate unit
    typedef struct packed {
        logic             blk_add;
        logic             blk_sub;
        logic             update;
        logic [CNT_W-1:0] blocks;
    } t_rate_req;

    // Limits and state reported by the rate unit
    typedef struct packed {
        logic [CNT_W-1:0] user_limit;
        logic [CNT_W-1:0] gc_limit;
        logic             low;
    } t_rate_stat;

endpackage

`default_nettype wire

// File: design/wbrl_buf_mem.sv
// ----------------------------------------------------------------------------
// wbrl_buf_mem
// Per-buffer state memory: one write port, one read port with registered
// read data. Entries never written since reset read as all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wbrl_buf_mem
    import wbrl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire t_buf_entry        i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output t_buf_entry             o_rdata
);

    t_buf_entry r_mem [NUM_BUFFERS];
    t_buf_entry r_mem_q;
    logic       r_vld [NUM_BUFFERS];
    logic       r_rd_vld;

    // Storage array and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_mem_q <= r_mem[i_raddr];
        end
    end

    // Written-since-reset flags, one per entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BUFFERS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_mem_q : '0;

endmodule

`default_nettype wire

// File: design/wbrl_rate.sv
// ----------------------------------------------------------------------------
// wbrl_rate
// Global free-block count and rate update: splits the buffer budget into
// a user limit and a GC limit from the free-block count.
// ----------------------------------------------------------------------------
`default_nettype none

module wbrl_rate
    import wbrl_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_rate_cfg i_cfg,
    input  wire t_rate_req i_req,
    output t_rate_stat     o_stat
);

    localparam int UM_W = FREE_W + WINDOW_ORDER;

    logic [FREE_W-1:0] r_free;
    logic [CNT_W-1:0]  r_user_limit;
    logic [CNT_W-1:0]  r_gc_limit;
    logic              r_low;

    logic [FREE_W:0]   add_sum;
    logic [FREE_W-1:0] n_free;
    logic [FREE_W-1:0] windows;
    logic [UM_W-1:0]   um;
    logic [CNT_W-1:0]  win_limit;
    logic [CNT_W-1:0]  win_gc;
    logic [CNT_W-1:0]  n_user_limit;
    logic [CNT_W-1:0]  n_gc_limit;
    logic              n_low;

    // Saturating free-count update
    always_comb begin
        add_sum = {1'b0, r_free} + (FREE_W+1)'(i_req.blocks);
        n_free  = r_free;
        if (i_req.blk_add) begin
            n_free = add_sum[FREE_W] ? FREE_MAX : add_sum[FREE_W-1:0];
        end else if (i_req.blk_sub) begin
            n_free = (r_free > FREE_W'(i_req.blocks)) ?
                     r_free - FREE_W'(i_req.blocks) : '0;
        end
    end

    // Limit split from the current free count
    always_comb begin
        windows   = r_free >> i_cfg.window_shift;
        um        = UM_W'(windows) << WINDOW_ORDER;
        win_limit = ((um >> CNT_W) != '0) ? CNT_MAX : um[CNT_W-1:0];
        win_gc    = (i_cfg.budget > win_limit) ? i_cfg.budget - win_limit : '0;
        if (r_free >= i_cfg.high_mark) begin
            n_user_limit = i_cfg.budget;
            n_gc_limit   = '0;
            n_low        = 1'b0;
        end else if (r_free <= i_cfg.reserve) begin
            n_user_limit = '0;
            n_gc_limit   = i_cfg.budget;
            n_low        = 1'b1;
        end else begin
            n_user_limit = win_limit;
            n_gc_limit   = win_gc;
            n_low        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free       <= '0;
            r_user_limit <= RST_BUDGET;
            r_gc_limit   <= '0;
            r_low        <= 1'b0;
        end else begin
            r_free <= n_free;
            if (i_req.update) begin
                r_user_limit <= n_user_limit;
                r_gc_limit   <= n_gc_limit;
                r_low        <= n_low;
            end
        end
    end

    assign o_stat.user_limit = r_user_limit;
    assign o_stat.gc_limit   = r_gc_limit;
    assign o_stat.low        = r_low;

endmodule

`default_nettype wire

// File: design/write_buffer_rate_limiter_top.sv
// ----------------------------------------------------------------------------
// write_buffer_rate_limiter_top
// Admission control for flash write buffers shared by user writes and GC.
//
// Input channel (i_valid / o_ready) takes one command beat; output channel
// (o_valid / i_ready) returns one result beat per command, in order.
// Per-buffer counts, active flags and idle timers live in a small memory
// with registered read data; each command reads the selected entry,
// modifies it and writes it back. A command passes the modify step and
// the done step, which loads its result, before the next can be taken.
// Tick walks every buffer's timer, one entry per cycle, catching the
// selected buffer on the way; its result goes through a report step
// and the done step after the walk, before the next accept.
// One command is in flight at a time; o_ready is high while idle, also
// while a result is still held in the output register. A finished result
// waits in the sequencer until the output register is free, so a stalled
// receiver holds up the next accept once one result waits behind it.
// Reset clears all counts, flags, timers and the free count, and loads the
// register defaults; the block accepts commands right after reset.
// Configuration writes take effect at the clock edge of the write.
// ----------------------------------------------------------------------------
`default_nettype none

module write_buffer_rate_limiter_top
    import wbrl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Command channel
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [IDX_W-1:0]      i_buffer_index,
    input  wire logic [CNT_W-1:0]      i_user_count,
    input  wire logic [CNT_W-1:0]      i_gc_count,
    input  wire logic [CNT_W-1:0]      i_line_blocks,
    // Result channel
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_user_verdict,
    output logic                       o_gc_allowed,
    output logic [1:0]                 o_gc_action,
    output logic                       o_rate_state,
    output logic [CNT_W-1:0]           o_user_limit
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_WALK,
        S_RPT,
        S_DONE
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BUFFERS - 1);

    // Configuration registers
    logic [FREE_W-1:0]  r_high_mark;
    logic [SHIFT_W-1:0] r_window_shift;
    logic [FREE_W-1:0]  r_reserve;
    logic [CNT_W-1:0]   r_budget;
    logic [CNT_W-1:0]   r_idle_timeout;

    // Sequencer registers
    t_state             r_state;
    t_cmd               r_cmd;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_idx_ok;
    logic [CNT_W-1:0]   r_ucnt;
    logic [CNT_W-1:0]   r_gcnt;
    logic [ADDR_W-1:0]  r_ptr;
    logic [CNT_W-1:0]   r_uc;
    logic [CNT_W-1:0]   r_gc;
    logic               r_act;
    logic               r_upd;

    logic               accept;
    t_cmd               in_cmd;
    logic [ADDR_W-1:0]  in_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    t_buf_entry         mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    t_buf_entry         rd_entry;
    t_buf_entry         mod_entry;
    t_buf_entry         tick_entry;
    logic [CNT_W:0]     u_sum;
    logic [CNT_W:0]     g_sum;
    logic               writes_entry;
    logic               out_free;
    t_rate_cfg          rate_cfg;
    t_rate_req          rate_req;
    t_rate_stat         rate_stat;

    assign in_cmd   = t_cmd'(i_cmd);
    assign in_addr  = ADDR_W'(i_buffer_index);
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !o_valid || i_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_mark    <= RST_HIGH_MARK;
            r_window_shift <= RST_WINDOW_SHIFT;
            r_reserve      <= RST_RESERVE;
            r_budget       <= RST_BUDGET;
            r_idle_timeout <= RST_IDLE_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HIGH_MARK:    r_high_mark    <= i_cfg_data[FREE_W-1:0];
                CFG_WINDOW_SHIFT: r_window_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_RESERVE:      r_reserve      <= i_cfg_data[FREE_W-1:0];
                CFG_BUDGET:       r_budget       <= i_cfg_data[CNT_W-1:0];
                CFG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Buffer state memory
    wbrl_buf_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_entry)
    );

    // Rate unit: free count moves at accept, limits at the modify step
    assign rate_cfg.high_mark    = r_high_mark;
    assign rate_cfg.window_shift = r_window_shift;
    assign rate_cfg.reserve      = r_reserve;
    assign rate_cfg.budget       = r_budget;

    assign rate_req.blk_add = accept && (in_cmd == CMD_FREE_INC);
    assign rate_req.blk_sub = accept && (in_cmd == CMD_FREE_DEC);
    assign rate_req.blocks  = i_line_blocks;
    assign rate_req.update  = (r_state == S_MOD) &&
                              ((r_cmd == CMD_FREE_INC) || (r_cmd == CMD_KICK));

    wbrl_rate u_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (rate_cfg),
        .i_req   (rate_req),
        .o_stat  (rate_stat)
    );

    // Modify the selected entry for insert and remove commands
    always_comb begin
        u_sum     = {1'b0, rd_entry.user_cnt} + {1'b0, r_ucnt};
        g_sum     = {1'b0, rd_entry.gc_cnt} + {1'b0, r_gcnt};
        mod_entry = rd_entry;
        case (r_cmd)
            CMD_USER_IN: begin
                mod_entry.user_cnt  = u_sum[CNT_W] ? CNT_MAX : u_sum[CNT_W-1:0];
                mod_entry.active    = 1'b1;
                mod_entry.countdown = (r_idle_timeout == '0) ? CNT_W'(1) : r_idle_timeout;
            end
            CMD_GC_IN: begin
                mod_entry.gc_cnt = g_sum[CNT_W] ? CNT_MAX : g_sum[CNT_W-1:0];
            end
            CMD_OUT: begin
                mod_entry.user_cnt = (rd_entry.user_cnt > r_ucnt) ?
                                     rd_entry.user_cnt - r_ucnt : '0;
                mod_entry.gc_cnt   = (rd_entry.gc_cnt > r_gcnt) ?
                                     rd_entry.gc_cnt - r_gcnt : '0;
            end
            default: ;
        endcase
        writes_entry = r_idx_ok && ((r_cmd == CMD_USER_IN) || (r_cmd == CMD_GC_IN) ||
                                    (r_cmd == CMD_OUT));
    end

    // Advance one idle timer; clear the active flag when it expires
    always_comb begin
        tick_entry = rd_entry;
        if (rd_entry.countdown != '0) begin
            tick_entry.countdown = rd_entry.countdown - CNT_W'(1);
            if (rd_entry.countdown == CNT_W'(1)) begin
                tick_entry.active = 1'b0;
            end
        end
    end

    // Memory port control; the walk prefetches the next entry until the last
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_addr;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = mod_entry;
        unique case (r_state)
            S_IDLE: begin
                mem_re    = accept;
                mem_raddr = (in_cmd == CMD_TICK) ? '0 : in_addr;
            end
            S_MOD: begin
                mem_we = writes_entry;
            end
            S_WALK: begin
                mem_we    = (rd_entry.countdown != '0);
                mem_waddr = r_ptr;
                mem_wdata = tick_entry;
                mem_re    = (r_ptr != LAST_ADDR);
                mem_raddr = r_ptr + ADDR_W'(1);
            end
            default: ;
        endcase
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= in_cmd;
                        r_addr   <= in_addr;
                        r_idx_ok <= (32'(i_buffer_index) < NUM_BUFFERS);
                        r_ucnt   <= i_user_count;
                        r_gcnt   <= i_gc_count;
                        r_ptr    <= '0;
                        r_state  <= (in_cmd == CMD_TICK) ? S_WALK : S_MOD;
                    end
                end
                S_MOD: begin
                    r_uc    <= r_idx_ok ? mod_entry.user_cnt : '0;
                    r_gc    <= r_idx_ok ? mod_entry.gc_cnt : '0;
                    r_act   <= r_idx_ok && mod_entry.active;
                    r_upd   <= rate_req.update;
                    r_state <= S_DONE;
                end
                S_WALK: begin
                    // Catch the selected buffer as the walk passes it
                    if (r_ptr == r_addr) begin
                        r_uc  <= r_idx_ok ? tick_entry.user_cnt : '0;
                        r_gc  <= r_idx_ok ? tick_entry.gc_cnt : '0;
                        r_act <= r_idx_ok && tick_entry.active;
                    end
                    if (r_ptr == LAST_ADDR) begin
                        r_state <= S_RPT;
                    end else begin
                        r_ptr <= r_ptr + ADDR_W'(1);
                    end
                end
                S_RPT: begin
                    r_upd   <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_valid        <= 1'b1;
                        o_user_verdict <= (r_uc >= rate_stat.user_limit);
                        o_gc_allowed   <= !((r_gc >= rate_stat.gc_limit) && r_act);
                        o_gc_action    <= !r_upd ? ACT_NONE :
                                          (rate_stat.low ? ACT_START : ACT_STOP);
                        o_rate_state   <= rate_stat.low;
                        o_user_limit   <= rate_stat.user_limit;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A finished result lands in the output register
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> o_valid)
        else $error("finished result not presented");

    // An accepted beat starts either the modify step or the timer walk
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_MOD || r_state == S_WALK))
        else $error("accepted beat did not start work");

    // A timer walk begins at the first buffer
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && $past(r_state) == S_IDLE) |-> (r_ptr == '0))
        else $error("timer walk did not start at buffer zero");

    // Never read and write the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of one entry in the same cycle");

    // Stop-GC is reported only in the high state, start-GC only in the low
    a_action_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gc_action != ACT_NONE) |->
        ((o_gc_action == ACT_START) == o_rate_state))
        else $error("gc action disagrees with rate state");

endmodule

`default_nettype wire
